### rtl/core/ctwb_pkg.sv
// Shared types, constants and the blackbody white reference table for white balance.
`default_nettype none

package ctwb_pkg;

  localparam int PIX_W   = 8;
  localparam int TEMP_W  = 14;
  localparam int STEP_W  = 8;
  localparam int IDX_W   = 7;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam int    TABLE_ENTRIES = 111;
  localparam pix_t  PIX_MAX       = 8'd255;
  localparam temp_t TEMP_RESET    = 14'd1000;

  // floor(t / 100) for any 14-bit t equals (t * 5243) >> 19.
  localparam int STEP_RECIP  = 5243;
  localparam int STEP_SHIFT  = 19;
  localparam int STEP_MUL_W  = 27;
  // The first table entry belongs to 1000 K, which is step 10.
  localparam step_t STEP_BASE = 8'd10;
  localparam step_t STEP_SPAN = 8'd111;
  localparam idx_t  IDX_LAST  = 7'd110;

  localparam pix_t WHITE_R [TABLE_ENTRIES] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd252, 8'd249, 8'd247,
    8'd245, 8'd243, 8'd240, 8'd239, 8'd237, 8'd235, 8'd233, 8'd231, 8'd230, 8'd228,
    8'd227, 8'd225, 8'd224, 8'd222, 8'd221, 8'd220, 8'd218, 8'd217, 8'd216, 8'd215,
    8'd214, 8'd212, 8'd211, 8'd210, 8'd209, 8'd208, 8'd207, 8'd207, 8'd206, 8'd205,
    8'd207, 8'd207, 8'd206, 8'd205, 8'd204, 8'd204, 8'd203, 8'd202, 8'd202, 8'd201,
    8'd200, 8'd200, 8'd199, 8'd198, 8'd198, 8'd197, 8'd197, 8'd197, 8'd196, 8'd195,
    8'd195
  };

  localparam pix_t WHITE_G [TABLE_ENTRIES] = '{
    8'd56,  8'd71,  8'd83,  8'd93,  8'd101, 8'd109, 8'd115, 8'd121, 8'd126, 8'd131,
    8'd138, 8'd142, 8'd147, 8'd152, 8'd157, 8'd161, 8'd165, 8'd169, 8'd173, 8'd177,
    8'd180, 8'd184, 8'd187, 8'd190, 8'd193, 8'd196, 8'd199, 8'd201, 8'd204, 8'd206,
    8'd209, 8'd211, 8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd223, 8'd225, 8'd227,
    8'd228, 8'd230, 8'd232, 8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd240, 8'd242,
    8'd243, 8'd244, 8'd245, 8'd246, 8'd248, 8'd249, 8'd249, 8'd247, 8'd246, 8'd245,
    8'd243, 8'd242, 8'd241, 8'd240, 8'd239, 8'd238, 8'd237, 8'd236, 8'd235, 8'd234,
    8'd233, 8'd232, 8'd231, 8'd230, 8'd230, 8'd229, 8'd229, 8'd227, 8'd227, 8'd226,
    8'd225, 8'd225, 8'd224, 8'd223, 8'd223, 8'd222, 8'd221, 8'd221, 8'd220, 8'd220,
    8'd218, 8'd218, 8'd217, 8'd217, 8'd216, 8'd216, 8'd215, 8'd215, 8'd214, 8'd214,
    8'd213, 8'd213, 8'd212, 8'd212, 8'd212, 8'd211, 8'd211, 8'd210, 8'd210, 8'd210,
    8'd209
  };

  localparam pix_t WHITE_B [TABLE_ENTRIES] = '{
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd18,  8'd33,  8'd44,  8'd54,  8'd63,  8'd72,  8'd79,  8'd87,  8'd94,  8'd101,
    8'd107, 8'd114, 8'd120, 8'd126, 8'd132, 8'd137, 8'd143, 8'd148, 8'd153, 8'd159,
    8'd163, 8'd168, 8'd173, 8'd177, 8'd182, 8'd186, 8'd190, 8'd194, 8'd198, 8'd202,
    8'd206, 8'd210, 8'd213, 8'd217, 8'd220, 8'd224, 8'd227, 8'd230, 8'd233, 8'd236,
    8'd239, 8'd242, 8'd245, 8'd247, 8'd251, 8'd253, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255
  };

endpackage

`default_nettype wire

### rtl/core/color_temperature_white_balance_top.sv
// Top level of the color temperature white balance pipeline.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_blue_in, in_green_in, in_red_in
//   out_      output     out_valid/out_stall out_blue_out, out_green_out, out_red_out
//   cfg_      input      cfg_wr_en           cfg_temperature_kelvin
//
// One item enters per clock when nothing stalls and passes through four register stages.
// Stage 1 turns the temperature into a 100 K step with a reciprocal multiply,
// stage 2 looks the three gains up, stage 3 forms the products and stage 4
// truncates and saturates into the output register.
// A stalled output only holds the stages that are full; in_stall rises only when
// all four stages hold items and the output is stalled, so bubbles are squeezed out.
// Reset clears every valid bit and sets the temperature to 1000 K.
`default_nettype none

module color_temperature_white_balance_top #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  ctwb_pkg::temp_t cfg_temperature_kelvin,
  input  logic            in_valid,
  output logic            in_stall,
  input  ctwb_pkg::pix_t  in_blue_in,
  input  ctwb_pkg::pix_t  in_green_in,
  input  ctwb_pkg::pix_t  in_red_in,
  output logic            out_valid,
  input  logic            out_stall,
  output ctwb_pkg::pix_t  out_blue_out,
  output ctwb_pkg::pix_t  out_green_out,
  output ctwb_pkg::pix_t  out_red_out
);
  import ctwb_pkg::*;

  localparam int GAIN_W = GAIN_FRAC_BITS + PIX_W;
  localparam int PROD_W = GAIN_W + PIX_W;

  // The user must let the temperature register change only while no item is in flight;
  // the block itself does not enforce this. Only stage 1 reads the register directly.
  temp_t temperature_kelvin_r;
  temp_t temperature_kelvin_nxt;

  // Stage enables: a stage loads when it is empty or the next one loads.
  logic en1, en2, en3, en4;

  // Stage 1: pixel and temperature step.
  logic                  v1_r;
  pix_t                  b1_r, g1_r, r1_r;
  step_t                 step1_r;
  step_t                 step1_nxt;
  logic [STEP_MUL_W-1:0] step_prod;

  // Stage 2: pixel and gains.
  logic              v2_r;
  pix_t              b2_r, g2_r, r2_r;
  logic [GAIN_W-1:0] gb2_r, gg2_r, gr2_r;
  logic [GAIN_W-1:0] gb2_nxt, gg2_nxt, gr2_nxt;

  // Stage 3: full products.
  logic              v3_r;
  logic [PROD_W-1:0] pb3_r, pg3_r, pr3_r;
  logic [PROD_W-1:0] pb3_nxt, pg3_nxt, pr3_nxt;

  // Stage 4: output register.
  logic out_valid_r;
  pix_t ob_r, og_r, or_r;
  pix_t ob_nxt, og_nxt, or_nxt;

  function automatic pix_t saturate(input logic [PROD_W-1:0] prod);
    logic [PROD_W-GAIN_FRAC_BITS-1:0] scaled;
    scaled = prod[PROD_W-1:GAIN_FRAC_BITS];
    if (scaled > (PROD_W-GAIN_FRAC_BITS)'(PIX_MAX)) begin
      return PIX_MAX;
    end
    return scaled[PIX_W-1:0];
  endfunction

  assign en4      = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_comb begin
    temperature_kelvin_nxt = temperature_kelvin_r;
    if (cfg_wr_en) begin
      temperature_kelvin_nxt = cfg_temperature_kelvin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temperature_kelvin_r <= TEMP_RESET;
    end else begin
      temperature_kelvin_r <= temperature_kelvin_nxt;
    end
  end

  // floor(temperature / 100) through the reciprocal 5243 / 2^19.
  assign step_prod = STEP_MUL_W'(temperature_kelvin_r) * STEP_MUL_W'(STEP_RECIP);
  assign step1_nxt = step_prod[STEP_SHIFT +: STEP_W];

  ctwb_gain_lut #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_gain_lut (
    .step      (step1_r),
    .gain_red  (gr2_nxt),
    .gain_green(gg2_nxt),
    .gain_blue (gb2_nxt)
  );

  assign pb3_nxt = PROD_W'(b2_r) * PROD_W'(gb2_r);
  assign pg3_nxt = PROD_W'(g2_r) * PROD_W'(gg2_r);
  assign pr3_nxt = PROD_W'(r2_r) * PROD_W'(gr2_r);

  assign ob_nxt = saturate(pb3_r);
  assign og_nxt = saturate(pg3_r);
  assign or_nxt = saturate(pr3_r);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // Payload registers travel with their valid bits.
  always_ff @(posedge clk) begin
    if (en1) begin
      b1_r    <= in_blue_in;
      g1_r    <= in_green_in;
      r1_r    <= in_red_in;
      step1_r <= step1_nxt;
    end
    if (en2) begin
      b2_r  <= b1_r;
      g2_r  <= g1_r;
      r2_r  <= r1_r;
      gb2_r <= gb2_nxt;
      gg2_r <= gg2_nxt;
      gr2_r <= gr2_nxt;
    end
    if (en3) begin
      pb3_r <= pb3_nxt;
      pg3_r <= pg3_nxt;
      pr3_r <= pr3_nxt;
    end
    if (en4) begin
      ob_r <= ob_nxt;
      og_r <= og_nxt;
      or_r <= or_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue_out  = ob_r;
  assign out_green_out = og_r;
  assign out_red_out   = or_r;

endmodule

`default_nettype wire

### rtl/core/ctwb_gain_lut.sv
// Temperature step to table index clamp and per-channel fixed-point gain lookup.
`default_nettype none

module ctwb_gain_lut #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  ctwb_pkg::step_t               step,
  output logic [GAIN_FRAC_BITS+8-1:0]   gain_red,
  output logic [GAIN_FRAC_BITS+8-1:0]   gain_green,
  output logic [GAIN_FRAC_BITS+8-1:0]   gain_blue
);
  import ctwb_pkg::*;

  localparam int GAIN_W = GAIN_FRAC_BITS + PIX_W;

  logic [GAIN_W-1:0] red_gain_tab   [TABLE_ENTRIES];
  logic [GAIN_W-1:0] green_gain_tab [TABLE_ENTRIES];
  logic [GAIN_W-1:0] blue_gain_tab  [TABLE_ENTRIES];
  step_t             offset;
  idx_t              idx;

  // Gains are floor((255 << F) / white), all worked out at elaboration.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_gain
    localparam longint unsigned NUM  = 64'(PIX_MAX) << GAIN_FRAC_BITS;
    localparam longint unsigned GR   = NUM / 64'(WHITE_R[i]);
    localparam longint unsigned GG   = NUM / 64'(WHITE_G[i]);
    localparam longint unsigned GB   = NUM / 64'(WHITE_B[i]);
    assign red_gain_tab[i]   = GAIN_W'(GR);
    assign green_gain_tab[i] = GAIN_W'(GG);
    assign blue_gain_tab[i]  = GAIN_W'(GB);
  end

  always_comb begin
    offset = step - STEP_BASE;
    if (step < STEP_BASE) begin
      idx = '0;
    end else if (offset >= STEP_SPAN) begin
      idx = IDX_LAST;
    end else begin
      idx = offset[IDX_W-1:0];
    end
  end

  assign gain_red   = red_gain_tab[idx];
  assign gain_green = green_gain_tab[idx];
  assign gain_blue  = blue_gain_tab[idx];

endmodule

`default_nettype wire

### rtl/core/ctwb_checker.sv
// Port-level checker for the white balance pipeline and its bind to the top level.
`default_nettype none

module ctwb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input ctwb_pkg::pix_t out_blue_out,
  input ctwb_pkg::pix_t out_green_out,
  input ctwb_pkg::pix_t out_red_out
);

  // Reset empties the pipeline, so the next cycle shows no result.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // An empty pipeline never pushes back.
  a_reset_no_stall: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // Back-pressure at the input comes only from a full, stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result item stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_blue_out)
      && $stable(out_green_out) && $stable(out_red_out)))
    else $error("stalled result item changed");

endmodule

bind color_temperature_white_balance_top ctwb_checker u_ctwb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_blue_out (out_blue_out),
  .out_green_out(out_green_out),
  .out_red_out  (out_red_out)
);

`default_nettype wire
